### sv/assert_macros.svh
// Assertion macros shared by the temperature readout RTL.
// Each macro expects i_clk and the active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/tssr_pkg.sv
// Package for the temperature seven-segment readout: constants, types and
// small lookup functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tssr_pkg;

    localparam int CFG_W     = 11;
    localparam int SAMPLE_W  = 12;
    localparam int QUO_W     = 22;
    localparam int BIT_W     = 5;
    localparam int TENTHS_W  = 12;
    localparam int DEN2_W    = 15;
    localparam int RECIP_W   = 30;
    localparam int RECIP_SH  = 41;

    localparam logic [CFG_W-1:0]  CFG_RESET   = 11'd1000;
    localparam logic [21:0]       VOLT_SCALE  = 22'd3300000;
    localparam logic [23:0]       OFFSET_UV   = 24'd400000;
    localparam logic [27:0]       F_OFFSET    = 28'd3120000;
    localparam logic [DEN2_W-1:0] DEN_C       = 15'd1950;
    localparam logic [DEN2_W-1:0] DEN_F       = 15'd9750;

    // Reciprocals of twice the denominators, rounded up, scaled by 2^RECIP_SH.
    // They give exact quotients for every rounding numerator below 2^26.
    localparam logic [RECIP_W-1:0] RECIP_C = 30'd563852117;
    localparam logic [RECIP_W-1:0] RECIP_F = 30'd112770424;

    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_C     = 8'h39;
    localparam logic [7:0] SEG_F     = 8'h71;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV1,
        B_TEMP,
        B_DIV2,
        B_DIGIT,
        B_EMIT
    } t_back_state;

    typedef enum logic [2:0] {
        P_MINUS,
        P_HUND,
        P_TENS,
        P_ONES,
        P_TENTH,
        P_UNIT
    } t_pos;

    function automatic logic [7:0] digit_seg(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0: seg = 8'h3F;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5B;
            4'd3: seg = 8'h4F;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6D;
            4'd6: seg = 8'h7D;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7F;
            4'd9: seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Place values of the tenths count, most significant first.
    function automatic logic [TENTHS_W-1:0] place_value(input logic [1:0] idx);
        logic [TENTHS_W-1:0] p;
        case (idx)
            2'd0: p = 12'd1000;
            2'd1: p = 12'd100;
            2'd2: p = 12'd10;
            default: p = 12'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### sv/tssr_fifo.sv
// Two-entry queue carrying closed windows from the front to the back end.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tssr_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    localparam int DEPTH = 2;

    logic [W-1:0] r_mem [DEPTH];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_push && !i_pop, r_count != 2'(DEPTH))

endmodule

`default_nettype wire

### sv/tssr_front.sv
// Front end: accepts samples, sums each window and latches the unit select.
// Depends on tssr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tssr_front #(
    parameter int AW = 12,
    parameter int CW = 11,
    parameter int SW = 23,
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tssr_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  wire logic                          i_fahrenheit,
    input  wire logic                          i_cfg_we,
    input  wire logic [tssr_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                               o_push,
    output logic [SW+CW:0]                     o_wdata,
    input  wire logic                          i_full
);

    localparam int TW = (CW > tssr_pkg::CFG_W) ? CW : tssr_pkg::CFG_W;

    logic [tssr_pkg::CFG_W-1:0] r_cfg;
    logic [SW-1:0]              r_sum;
    logic [CW-1:0]              r_taken;
    logic                       r_unit;

    logic [TW-1:0] cfg_ext;
    logic [TW-1:0] target;
    logic [SW-1:0] n_sum;
    logic [CW-1:0] n_taken;
    logic          n_unit;
    logic          accept;
    logic          close;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // A count of zero means one; counts past the limit clamp to it.
    always_comb begin
        cfg_ext = TW'(r_cfg);
        if (r_cfg == '0) begin
            target = TW'(1);
        end else if (cfg_ext > TW'(MAX_SAMPLES)) begin
            target = TW'(MAX_SAMPLES);
        end else begin
            target = cfg_ext;
        end
    end

    assign n_sum   = r_sum + SW'(i_adc_sample[AW-1:0]);
    assign n_taken = r_taken + CW'(1);
    assign n_unit  = (r_taken == '0) ? i_fahrenheit : r_unit;
    assign close   = (TW'(n_taken) >= target);

    assign o_push  = accept && close;
    assign o_wdata = {n_unit, n_taken, n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= tssr_pkg::CFG_RESET;
            r_sum   <= '0;
            r_taken <= '0;
            r_unit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (accept) begin
                r_unit <= n_unit;
                if (close) begin
                    r_sum   <= '0;
                    r_taken <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_taken <= n_taken;
                end
            end
        end
    end

    `ASSERT_NEXT(a_close_clears, o_push, r_taken == '0 && r_sum == '0)

endmodule

`default_nettype wire

### sv/tssr_back.sv
// Back end: converts a closed window to tenths of a degree with a restoring
// divider for the average and a reciprocal multiply for the rounding, splits
// it into digits and emits the segment codes.
// Depends on tssr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tssr_back #(
    parameter int ADC_BITS = 12,
    parameter int CW = 11,
    parameter int SW = 23
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [SW+CW:0] i_rdata,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_segments,
    output logic                o_last
);

    localparam int QW   = tssr_pkg::QUO_W;
    localparam int NUMW = SW + 22;
    localparam int DW   = CW + ADC_BITS;
    localparam int XW   = (DW > tssr_pkg::DEN2_W) ? DW : tssr_pkg::DEN2_W;
    localparam int WW   = ((NUMW > XW + QW) ? NUMW : XW + QW) + 1;
    localparam int PW   = 28 + tssr_pkg::RECIP_W;
    localparam logic [ADC_BITS-1:0] FULL = '1;

    tssr_pkg::t_back_state r_state, n_state;
    tssr_pkg::t_pos        r_pos;

    logic [NUMW-1:0]             r_num;
    logic [DW-1:0]               r_den;
    logic                        r_unit;
    logic [WW-1:0]               r_rem;
    logic [WW-1:0]               r_sdiv;
    logic [QW-1:0]               r_quo;
    logic [tssr_pkg::BIT_W-1:0]  r_bit;
    logic                        r_neg;
    logic [tssr_pkg::TENTHS_W-1:0] r_val;
    logic [1:0]                  r_pidx;
    logic [3:0]                  r_cnt;
    logic [3:0]                  r_dig [4];
    logic                        r_out_valid;
    logic [7:0]                  r_seg;
    logic                        r_last;

    logic [SW-1:0]  q_sum;
    logic [CW-1:0]  q_count;
    logic           q_unit;
    logic           div_ge;
    logic [QW-1:0]  quo_step;
    logic           out_load;
    logic           pos_last;
    logic [23:0]    d_uv;
    logic [27:0]    d_ext;
    logic [27:0]    num_t;
    logic [26:0]    mag;
    logic [tssr_pkg::DEN2_W-1:0] den_t;
    logic [27:0]    numer2;
    logic [tssr_pkg::RECIP_W-1:0] recip;
    logic [PW-1:0]  recip_prod;
    logic [tssr_pkg::TENTHS_W-1:0] pval;
    tssr_pkg::t_pos first_pos;
    tssr_pkg::t_pos next_pos;
    logic [7:0]     seg_sel;

    assign {q_unit, q_count, q_sum} = i_rdata;

    assign div_ge   = (r_rem >= r_sdiv);
    assign quo_step = {r_quo[QW-2:0], div_ge};

    // Offset removal, Fahrenheit scaling and magnitude of the numerator.
    always_comb begin
        d_uv  = {2'b00, r_quo} - tssr_pkg::OFFSET_UV;
        d_ext = {{4{d_uv[23]}}, d_uv};
        if (r_unit) begin
            num_t = (d_ext << 3) + d_ext + tssr_pkg::F_OFFSET;
            den_t = tssr_pkg::DEN_F;
        end else begin
            num_t = d_ext;
            den_t = tssr_pkg::DEN_C;
        end
        mag    = num_t[27] ? 27'(-num_t) : num_t[26:0];
        numer2 = {mag, 1'b0} + 28'(den_t);
    end

    // The rounding numerator stays below 2^26, so the scaled reciprocal
    // gives the exact floor of the division by twice the denominator.
    assign recip      = r_unit ? tssr_pkg::RECIP_F : tssr_pkg::RECIP_C;
    assign recip_prod = PW'(r_rem[27:0]) * PW'(recip);

    assign pval = tssr_pkg::place_value(r_pidx);

    always_comb begin
        if (r_dig[3] != 4'd0) begin
            first_pos = tssr_pkg::P_HUND;
        end else if (r_dig[2] != 4'd0) begin
            first_pos = tssr_pkg::P_TENS;
        end else begin
            first_pos = tssr_pkg::P_ONES;
        end
    end

    always_comb begin
        pos_last = 1'b0;
        case (r_pos)
            tssr_pkg::P_MINUS: begin
                seg_sel  = tssr_pkg::SEG_MINUS;
                next_pos = first_pos;
            end
            tssr_pkg::P_HUND: begin
                seg_sel  = tssr_pkg::digit_seg(r_dig[3]);
                next_pos = tssr_pkg::P_TENS;
            end
            tssr_pkg::P_TENS: begin
                seg_sel  = tssr_pkg::digit_seg(r_dig[2]);
                next_pos = tssr_pkg::P_ONES;
            end
            tssr_pkg::P_ONES: begin
                seg_sel  = tssr_pkg::digit_seg(r_dig[1]);
                next_pos = tssr_pkg::P_TENTH;
            end
            tssr_pkg::P_TENTH: begin
                seg_sel  = tssr_pkg::digit_seg(r_dig[0]) | tssr_pkg::SEG_DOT;
                next_pos = tssr_pkg::P_UNIT;
            end
            tssr_pkg::P_UNIT: begin
                seg_sel  = r_unit ? tssr_pkg::SEG_F : tssr_pkg::SEG_C;
                next_pos = tssr_pkg::P_UNIT;
                pos_last = 1'b1;
            end
            default: begin
                seg_sel  = 8'h00;
                next_pos = tssr_pkg::P_UNIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tssr_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            tssr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = tssr_pkg::B_MUL;
                end
            end
            tssr_pkg::B_MUL: begin
                n_state = tssr_pkg::B_DIV1;
            end
            tssr_pkg::B_DIV1: begin
                if (r_bit == '0) begin
                    n_state = tssr_pkg::B_TEMP;
                end
            end
            tssr_pkg::B_TEMP: begin
                n_state = tssr_pkg::B_DIV2;
            end
            tssr_pkg::B_DIV2: begin
                n_state = tssr_pkg::B_DIGIT;
            end
            tssr_pkg::B_DIGIT: begin
                if (r_val < pval && r_pidx == 2'd3) begin
                    n_state = tssr_pkg::B_EMIT;
                end
            end
            tssr_pkg::B_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    if (pos_last) begin
                        n_state = tssr_pkg::B_IDLE;
                    end
                end
            end
            default: begin
                n_state = tssr_pkg::B_IDLE;
            end
        endcase
    end

    // Datapath registers; they carry no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tssr_pkg::B_IDLE: begin
                r_num  <= NUMW'(q_sum) * NUMW'(tssr_pkg::VOLT_SCALE);
                r_den  <= DW'(q_count) * DW'(FULL);
                r_unit <= q_unit;
            end
            tssr_pkg::B_MUL: begin
                r_rem  <= WW'(r_num);
                r_sdiv <= WW'(r_den) << (QW - 1);
                r_quo  <= '0;
                r_bit  <= tssr_pkg::BIT_W'(QW - 1);
            end
            tssr_pkg::B_DIV1: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_sdiv;
                end
                r_sdiv <= r_sdiv >> 1;
                r_quo  <= quo_step;
                r_bit  <= r_bit - tssr_pkg::BIT_W'(1);
            end
            tssr_pkg::B_TEMP: begin
                r_neg  <= num_t[27];
                r_rem  <= WW'(numer2);
            end
            tssr_pkg::B_DIV2: begin
                r_val  <= recip_prod[tssr_pkg::RECIP_SH +: tssr_pkg::TENTHS_W];
                r_pidx <= 2'd0;
                r_cnt  <= 4'd0;
            end
            tssr_pkg::B_DIGIT: begin
                if (r_val >= pval) begin
                    r_val <= r_val - pval;
                    r_cnt <= r_cnt + 4'd1;
                end else begin
                    r_dig[2'd3 - r_pidx] <= r_cnt;
                    r_cnt  <= 4'd0;
                    r_pidx <= r_pidx + 2'd1;
                    // The leading digits were stored on earlier steps.
                    r_pos  <= r_neg ? tssr_pkg::P_MINUS : first_pos;
                end
            end
            tssr_pkg::B_EMIT: begin
                if (out_load) begin
                    r_pos <= next_pos;
                end
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_seg  <= seg_sel;
            r_last <= pos_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_segments = r_seg;
    assign o_last     = r_last;

    `ASSERT_NEXT(a_div_done, r_state == tssr_pkg::B_DIV1 && r_bit == '0,
                 r_state == tssr_pkg::B_TEMP)
    `ASSERT_IMPL(a_last_unit, r_out_valid && r_last,
                 r_seg == tssr_pkg::SEG_C || r_seg == tssr_pkg::SEG_F)

endmodule

`default_nettype wire

### sv/temperature_seven_segment_readout.sv
// Seven-segment temperature readout built from a sample front end, a
// two-entry window queue and a conversion back end.
// Depends on tssr_pkg, tssr_front, tssr_fifo and tssr_back.
//
// Usage: samples arrive on i_valid/o_ready with i_adc_sample and i_fahrenheit.
// One sample is taken per cycle while the window queue has room. Every
// sample_count samples (written through i_cfg_we/i_cfg_data, reset 1000)
// close a window, and the block then produces a run of three to six items
// on o_valid/i_ready: optional minus, integer digits, tenths digit with the
// decimal point, and the unit letter with o_last set.
// After the closing sample is taken, the back end performs one pop, one
// multiply stage, 22 steps of the restoring divider for the average, one
// offset stage, one reciprocal multiply for the rounding, 4 to 32 digit
// subtraction steps and one output load. The codes then follow one per
// cycle while the receiver is ready.
// The output holds in a register while the receiver stalls; up to two
// further windows queue up before o_ready drops.
// Reset (synchronous, active low) empties the queue, clears the running
// sum and count, selects Celsius and loads the sample count of 1000.
`timescale 1ns / 1ps
`default_nettype none

module temperature_seven_segment_readout #(
    parameter int ADC_BITS    = 12,
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tssr_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  wire logic                          i_fahrenheit,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_segments,
    output logic                               o_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [tssr_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW = (ADC_BITS < tssr_pkg::SAMPLE_W) ? ADC_BITS : tssr_pkg::SAMPLE_W;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = AW + CW;

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic [SW+CW:0] wdata;
    logic [SW+CW:0] rdata;

    tssr_front #(
        .AW          (AW),
        .CW          (CW),
        .SW          (SW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_adc_sample (i_adc_sample),
        .i_fahrenheit (i_fahrenheit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_wdata      (wdata),
        .i_full       (full)
    );

    tssr_fifo #(
        .W (SW + CW + 1)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wdata),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (rdata),
        .o_empty (empty)
    );

    tssr_back #(
        .ADC_BITS (ADC_BITS),
        .CW       (CW),
        .SW       (SW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rdata    (rdata),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_segments (o_segments),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

### verif/temperature_seven_segment_readout_test.sv
// Testbench for the seven-segment temperature readout: sample windows in,
// display code runs out, checked against an internal predictor.
// Depends on tssr_pkg and temperature_seven_segment_readout.
`timescale 1ns / 1ps

module temperature_seven_segment_readout_test;

    localparam int MAX_SAMPLES = 1024;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CFG_SETTLE = 150;

    typedef struct packed {
        logic [7:0] segments;
        logic       last;
    } t_code;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [tssr_pkg::SAMPLE_W-1:0] i_adc_sample = '0;
    logic                          i_fahrenheit = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [7:0]                    o_segments;
    logic                          o_last;
    logic                          i_cfg_we = 1'b0;
    logic [tssr_pkg::CFG_W-1:0]    i_cfg_data = '0;

    // Predictor state.
    logic [tssr_pkg::CFG_W-1:0] window_len = tssr_pkg::CFG_RESET;
    logic [31:0]      sum_acc = 0;
    int unsigned      taken = 0;
    logic             unit_f = 1'b0;

    t_code       code_queue[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    temperature_seven_segment_readout u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_adc_sample(i_adc_sample),
        .i_fahrenheit(i_fahrenheit),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_segments  (o_segments),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL temperature_seven_segment_readout");
            $finish;
        end
    end

    function automatic logic [7:0] seg_of(input int unsigned digit);
        case (digit)
            0: return 8'h3F;
            1: return 8'h06;
            2: return 8'h5B;
            3: return 8'h4F;
            4: return 8'h66;
            5: return 8'h6D;
            6: return 8'h7D;
            7: return 8'h07;
            8: return 8'h7F;
            default: return 8'h6F;
        endcase
    endfunction

    // Updates the window state for one sample and queues the display run
    // when the sample closes the window.
    task automatic predict_reading(input logic [tssr_pkg::SAMPLE_W-1:0] smp,
                                   input logic fahr);
        longint unsigned target;
        longint unsigned volts;
        longint unsigned mag;
        longint unsigned tenths;
        longint unsigned ip;
        longint unsigned p10;
        longint          delta;
        longint          num;
        longint          den;
        target = window_len;
        if (target == 0) target = 1;
        if (target > MAX_SAMPLES) target = MAX_SAMPLES;
        if (taken == 0) unit_f = fahr;
        sum_acc = sum_acc + smp;
        taken++;
        if (taken < target) return;
        volts = (longint'(sum_acc) * 3300000) / (longint'(taken) * 4095);
        sum_acc = 0;
        taken = 0;
        delta = longint'(volts) - 400000;
        if (unit_f) begin
            num = 9 * delta + 3120000;
            den = 9750;
        end else begin
            num = delta;
            den = 1950;
        end
        mag = (num < 0) ? -num : num;
        tenths = (2 * mag + den) / (2 * den);
        ip = tenths / 10;
        if (num < 0) code_queue.push_back('{tssr_pkg::SEG_MINUS, 1'b0});
        p10 = 1;
        while (p10 * 10 <= ip && p10 < 100) p10 *= 10;
        while (p10 > 0) begin
            code_queue.push_back('{seg_of(32'((ip / p10) % 10)), 1'b0});
            ip %= p10;
            p10 /= 10;
        end
        code_queue.push_back('{seg_of(32'(tenths % 10)) | tssr_pkg::SEG_DOT, 1'b0});
        code_queue.push_back('{unit_f ? tssr_pkg::SEG_F : tssr_pkg::SEG_C, 1'b1});
    endtask

    // Receiver: random stalls and the check of each accepted item.
    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n && o_valid && i_ready) begin
            if (code_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item segments=%h last=%b", o_segments, o_last);
            end else begin
                want = code_queue.pop_front();
                if (o_segments !== want.segments || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected segments=%h last=%b, got %h %b",
                                 want.segments, want.last, o_segments, o_last);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high after an accepted item until the sender idles, so
    // items can follow back to back.
    task automatic send_sample(input logic [tssr_pkg::SAMPLE_W-1:0] smp, input logic fahr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_adc_sample <= smp;
        i_fahrenheit <= fahr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_reading(smp, fahr);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    // Only written with the block idle; no partial window should be pending, which this task does not enforce.
    task automatic write_window_len(input logic [tssr_pkg::CFG_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_len = value;
    endtask

    task automatic test_extremes();
        write_window_len(1);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd496, 1'b0);  // just under 0.4 V, minus sign on 0.0
        send_sample(12'd495, 1'b0);  // reads minus 0.1
        send_sample(12'd1241, 1'b1);
        send_sample(12'd620, 1'b0);
        send_sample(12'd2730, 1'b0);
        send_sample(12'hAAA, 1'b1);
        send_sample(12'h555, 1'b0);
        write_window_len(0);  // acts as one
        send_sample(12'd100, 1'b1);
        send_sample(12'd3000, 1'b0);
    endtask

    task automatic test_window_sizes();
        write_window_len(3);
        repeat (6) send_sample(12'($urandom_range(4095)), 1'($urandom_range(1)));
        // Clipped to the maximum window; the first sample after the next count write closes it.
        write_window_len(11'd2047);
        repeat (16) send_sample(12'($urandom_range(4095)), 1'($urandom_range(1)));
    endtask

    // A count lowered mid-window closes it on the next sample.
    task automatic test_count_change();
        write_window_len(5);
        wait_drained();
        repeat (3) send_sample(12'($urandom_range(4095)), 1'b1);
        i_valid <= 1'b0;
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 11'd2;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_len = 11'd2;
        send_sample(12'($urandom_range(4095)), 1'b0);
    endtask

    task automatic test_random(input int unsigned n);
        repeat (n) begin
            if ($urandom_range(9) == 0)
                write_window_len(11'($urandom_range(1, 4)));
            send_sample(12'($urandom_range(4095)), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 20;
        recv_idle_pct = 75;
        test_extremes();
        test_window_sizes();
        test_random(30);
        send_idle_pct = 75;
        recv_idle_pct = 20;
        test_count_change();
        test_random(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(30);
        write_window_len(tssr_pkg::CFG_RESET);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && code_queue.size() == 0) begin
            $display("PASS temperature_seven_segment_readout");
        end else begin
            $display("FAIL temperature_seven_segment_readout");
        end
        $finish;
    end
endmodule
